### design/fq8_pkg.sv
// ----------------------------------------------------------------------------
// fq8_pkg
// Shared types and helpers for the single-precision to int8 quantizer.
// ----------------------------------------------------------------------------
package fq8_pkg;

    localparam int unsigned FP_W    = 32;
    localparam int unsigned MANT_W  = 24;
    localparam int unsigned EXP_W   = 8;
    localparam int unsigned LZ_W    = 5;
    localparam int unsigned PROD_W  = 2 * MANT_W;
    localparam int unsigned XEXP_W  = 11;
    localparam int unsigned Q_W     = 8;

    localparam logic [FP_W-1:0] SCALE_RESET = 32'h3F80_0000;
    localparam logic [EXP_W-1:0] EXP_MAX    = 8'hFF;
    // Both operands carry a bias of 127 plus 23 fraction bits.
    localparam logic [XEXP_W-1:0] EXP_OFFSET = 11'd300;
    localparam logic signed [Q_W-1:0] Q_POS_SAT = 8'sd127;
    localparam logic signed [Q_W-1:0] Q_NEG_SAT = -8'sd127;
    localparam logic signed [Q_W-1:0] Q_FORBIDDEN = -8'sd128;

    // Class of a product on its way down the pipeline.
    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_ZERO,
        KIND_BIG
    } kind_t;

    // One unpacked operand.
    typedef struct packed {
        logic              sign;
        logic [EXP_W-1:0]  exp_eff;
        logic [MANT_W-1:0] mant;
        logic [LZ_W-1:0]   lz;
        logic              is_nan;
        logic              is_inf;
        logic              is_zero;
    } opnd_t;

    // Sideband that travels with every item.
    typedef struct packed {
        logic  sign;
        kind_t kind;
        logic  last;
    } side_t;

    // Leading zeros of a significand; an all-zero word gives MANT_W.
    function automatic logic [LZ_W-1:0] lead_zeros(input logic [MANT_W-1:0] m);
        logic [LZ_W-1:0] cnt;
        cnt = LZ_W'(MANT_W);
        for (int i = 0; i < MANT_W; i++) begin
            if (m[i])
            begin
                cnt = LZ_W'(MANT_W - 1 - i);
            end
        end
        return cnt;
    endfunction

endpackage

### design/fq8_if.sv
// ----------------------------------------------------------------------------
// fq8 channel interfaces
// Valid/ready channels for input values and quantized results.
// ----------------------------------------------------------------------------
interface fq8_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        last_element;

    modport source (output valid, output value_bits, output last_element, input ready);
    modport sink   (input valid, input value_bits, input last_element, output ready);
endinterface

interface fq8_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] quantized;
    logic              last_out;

    modport source (output valid, output quantized, output last_out, input ready);
    modport sink   (input valid, input quantized, input last_out, output ready);
endinterface

### design/fq8_unpack.sv
// ----------------------------------------------------------------------------
// fq8_unpack
// Split a single-precision pattern into sign, significand and exponent.
// ----------------------------------------------------------------------------
module fq8_unpack
    import fq8_pkg::*;
(
    input  logic [FP_W-1:0] bits,
    output opnd_t           op
);

    logic [EXP_W-1:0]    exp_f;
    logic [MANT_W-2:0]   frac_f;
    logic                exp_zero;
    logic                exp_ones;
    logic [MANT_W-1:0]   mant;

    assign exp_f    = bits[FP_W-2 -: EXP_W];
    assign frac_f   = bits[MANT_W-2:0];
    assign exp_zero = (exp_f == '0);
    assign exp_ones = (exp_f == EXP_MAX);
    // Subnormals get no hidden bit and the smallest normal exponent.
    assign mant     = {!exp_zero, frac_f};

    always_comb
    begin
        op.sign    = bits[FP_W-1];
        op.exp_eff = exp_zero ? EXP_W'(1) : exp_f;
        op.mant    = mant;
        op.lz      = lead_zeros(mant);
        op.is_nan  = exp_ones && (frac_f != '0);
        op.is_inf  = exp_ones && (frac_f == '0);
        op.is_zero = exp_zero && (frac_f == '0);
    end

endmodule

### design/float_to_int8_quantizer_core.sv
// ----------------------------------------------------------------------------
// float_to_int8_quantizer_core
// The input transfer loads stage 1; the item then moves on through stages 2, 3
// and 4 into the output register, holding in place while the next stage is full.
// Throughput: one item per cycle when not stalled; five stages (unpack, normalize,
// multiply, round to single, convert to int8) each hold one item and collapse bubbles.
// Reset: rst_n clears all stage valid bits and loads scale with 1.0.
// Symmetric int8 quantization of single-precision values by a scale.
// ----------------------------------------------------------------------------
module float_to_int8_quantizer_core
    import fq8_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [FP_W-1:0]   cfg_wdata,
    fq8_in_if.sink            in_ch,
    fq8_out_if.source         out_ch
);

    // ------------------------------------------------------------------
    // Scale register; the user must write it only while the pipeline is empty; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [FP_W-1:0] scale_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_bits_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_bits_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stall chain: a stage loads when it is empty or its successor moves.
    // ------------------------------------------------------------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, out_vld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !out_vld_reg || out_ch.ready;
    assign rdy4 = !s4_vld_reg  || rdy5;
    assign rdy3 = !s3_vld_reg  || rdy4;
    assign rdy2 = !s2_vld_reg  || rdy3;
    assign rdy1 = !s1_vld_reg  || rdy2;

    assign in_ch.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_vld_reg  <= in_ch.valid;
            if (rdy2) s2_vld_reg  <= s1_vld_reg;
            if (rdy3) s3_vld_reg  <= s2_vld_reg;
            if (rdy4) s4_vld_reg  <= s3_vld_reg;
            if (rdy5) out_vld_reg <= s4_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack both operands and classify the product.
    // ------------------------------------------------------------------
    opnd_t op_v, op_s;

    fq8_unpack u_unpack_value (.bits(in_ch.value_bits), .op(op_v));
    fq8_unpack u_unpack_scale (.bits(scale_bits_reg),   .op(op_s));

    side_t              s1_side_next;
    logic               prod_nan;

    side_t              s1_side_reg;
    logic [MANT_W-1:0]  s1_mv_reg, s1_ms_reg;
    logic [EXP_W-1:0]   s1_ev_reg, s1_es_reg;
    logic [LZ_W-1:0]    s1_lzv_reg, s1_lzs_reg;

    always_comb
    begin
        // Infinity times zero is invalid, like any NaN operand.
        prod_nan = op_v.is_nan || op_s.is_nan
                || (op_v.is_inf && op_s.is_zero) || (op_v.is_zero && op_s.is_inf);
        s1_side_next.sign = op_v.sign ^ op_s.sign;
        s1_side_next.last = in_ch.last_element;
        priority if (prod_nan || op_v.is_inf || op_s.is_inf)
            s1_side_next.kind = KIND_BIG;
        else if (op_v.is_zero || op_s.is_zero)
            s1_side_next.kind = KIND_ZERO;
        else
            s1_side_next.kind = KIND_NUM;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_ch.valid)
        begin
            s1_side_reg <= s1_side_next;
            s1_mv_reg   <= op_v.mant;
            s1_ms_reg   <= op_s.mant;
            s1_ev_reg   <= op_v.exp_eff;
            s1_es_reg   <= op_s.exp_eff;
            s1_lzv_reg  <= op_v.lz;
            s1_lzs_reg  <= op_s.lz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: normalize significands, form the product exponent.
    // Value = mant * 2^(exp_eff - 150); after the shift the leading one
    // sits at the top bit and the exponent drops by the shift.
    // ------------------------------------------------------------------
    logic [XEXP_W-1:0]  s2_ex_next;

    side_t              s2_side_reg;
    logic [MANT_W-1:0]  s2_nv_reg, s2_ns_reg;
    logic [XEXP_W-1:0]  s2_ex_reg;

    assign s2_ex_next = XEXP_W'(s1_ev_reg) - XEXP_W'(s1_lzv_reg)
                      + XEXP_W'(s1_es_reg) - XEXP_W'(s1_lzs_reg) - EXP_OFFSET;

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_vld_reg)
        begin
            s2_side_reg <= s1_side_reg;
            s2_nv_reg   <= s1_mv_reg << s1_lzv_reg;
            s2_ns_reg   <= s1_ms_reg << s1_lzs_reg;
            s2_ex_reg   <= s2_ex_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact significand product.
    // ------------------------------------------------------------------
    side_t              s3_side_reg;
    logic [PROD_W-1:0]  s3_prod_reg;
    logic [XEXP_W-1:0]  s3_ex_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_vld_reg)
        begin
            s3_side_reg <= s2_side_reg;
            s3_prod_reg <= s2_nv_reg * s2_ns_reg;
            s3_ex_reg   <= s2_ex_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round the product to 24 significant bits, nearest even.
    // Result is m * 2^pe with m in [2^23, 2^24). Results too small for a
    // normal single round differently, but stay far below one half.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]  p_norm;
    logic [XEXP_W-1:0]  e_norm;
    logic               rnd_up;
    logic [MANT_W:0]    m_sum;
    logic [MANT_W-1:0]  s4_m_next;
    logic [XEXP_W-1:0]  s4_pe_next;

    side_t                     s4_side_reg;
    logic [MANT_W-1:0]         s4_m_reg;
    logic signed [XEXP_W-1:0]  s4_pe_reg;

    always_comb
    begin
        if (s3_prod_reg[PROD_W-1])
        begin
            p_norm = s3_prod_reg;
            e_norm = s3_ex_reg;
        end
        else
        begin
            p_norm = s3_prod_reg << 1;
            e_norm = s3_ex_reg - XEXP_W'(1);
        end
        rnd_up = p_norm[MANT_W-1]
              && ((p_norm[MANT_W-2:0] != '0) || p_norm[MANT_W]);
        m_sum  = {1'b0, p_norm[PROD_W-1:MANT_W]} + (MANT_W+1)'(rnd_up);
        if (m_sum[MANT_W])
        begin
            // Carry out: renormalize to the smallest significand.
            s4_m_next  = {1'b1, {(MANT_W-1){1'b0}}};
            s4_pe_next = e_norm + XEXP_W'(MANT_W + 1);
        end
        else
        begin
            s4_m_next  = m_sum[MANT_W-1:0];
            s4_pe_next = e_norm + XEXP_W'(MANT_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_vld_reg)
        begin
            s4_side_reg <= s3_side_reg;
            s4_m_reg    <= s4_m_next;
            s4_pe_reg   <= s4_pe_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: integer rounding and saturation into the output register.
    // |p| >= 2^31 (pe >= 8) is the integer-indefinite case: -127.
    // |p| >= 128  (pe >= -16) saturates by sign.
    // |p| < 0.5   (pe <= -25) is zero.
    // Otherwise shift right by 17..24 and round half to even.
    // ------------------------------------------------------------------
    logic [XEXP_W-1:0]     neg_pe;
    logic [LZ_W-1:0]       sh;
    logic [MANT_W-1:0]     int_part;
    logic [MANT_W-1:0]     low_mask;
    logic                  half_bit;
    logic                  sticky;
    logic [Q_W-1:0]        mag;
    logic [Q_W-1:0]        mag_sat;
    logic signed [Q_W-1:0] q_next;

    logic signed [Q_W-1:0] out_q_reg;
    logic                  out_last_reg;

    always_comb
    begin
        neg_pe   = -s4_pe_reg;
        sh       = neg_pe[LZ_W-1:0];
        int_part = s4_m_reg >> sh;
        low_mask = (MANT_W'(1) << (sh - LZ_W'(1))) - MANT_W'(1);
        half_bit = s4_m_reg[sh - LZ_W'(1)];
        sticky   = (s4_m_reg & low_mask) != '0;
        mag      = int_part[Q_W-1:0] + Q_W'(half_bit && (sticky || int_part[0]));
        mag_sat  = (mag > Q_W'(Q_POS_SAT)) ? Q_W'(Q_POS_SAT) : mag;

        unique case (s4_side_reg.kind)
            KIND_BIG:  q_next = Q_NEG_SAT;
            KIND_ZERO: q_next = '0;
            KIND_NUM:
            begin
                priority if (s4_pe_reg >= 11'sd8)
                    q_next = Q_NEG_SAT;
                else if (s4_pe_reg >= -11'sd16)
                    q_next = s4_side_reg.sign ? Q_NEG_SAT : Q_POS_SAT;
                else if (s4_pe_reg <= -11'sd25)
                    q_next = '0;
                else
                    q_next = s4_side_reg.sign ? -$signed(mag_sat) : $signed(mag_sat);
            end
            default:   q_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && s4_vld_reg)
        begin
            out_q_reg    <= q_next;
            out_last_reg <= s4_side_reg.last;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.quantized = out_q_reg;
    assign out_ch.last_out  = out_last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_minus_128: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_q_reg != Q_FORBIDDEN))
        else $error("quantized result is -128");

    a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_vld_reg && !rdy4) |=> (s4_vld_reg && $stable(s4_m_reg) && $stable(s4_pe_reg)))
        else $error("stage 4 item lost or changed under stall");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && !rdy2) |=> (s2_vld_reg && $stable(s2_nv_reg) && $stable(s2_ex_reg)))
        else $error("stage 2 item lost or changed under stall");

endmodule

### tb/sv/tb_float_to_int8_quantizer_core.sv
// ----------------------------------------------------------------------------
// tb_float_to_int8_quantizer_core
// Self-checking bench for the float to int8 quantizer. A queue-fed driver
// pushes single-precision values through the input channel. A monitor checks
// every result against a predictor that rounds the scaled product to single
// precision and converts it with round-to-nearest-even. The bench runs through
// several scale settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_float_to_int8_quantizer_core;
    import fq8_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_element;
    } elem_t;

    typedef struct packed {
        logic signed [7:0] quantized;
        logic              last_out;
    } quant_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    fq8_in_if  in_ch();
    fq8_out_if out_ch();

    float_to_int8_quantizer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    elem_t       pending_elems[$];
    quant_t      expected_quants[$];
    logic [31:0] scale_now;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    int          cycle_count;

    // Clock: 10 time units per period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Exact real value of a finite single-precision pattern.
    function automatic real fp32_value(input logic [31:0] b);
        int   e;
        int   m;
        real  mag;
        e = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        m = (b[30:23] == 8'd0) ? int'(b[22:0]) : int'({1'b1, b[22:0]});
        mag = real'(m) * (2.0 ** (e - 150));
        return b[31] ? -mag : mag;
    endfunction

    // Scale one value: product rounded to single, then RNE to int, clamped.
    function automatic logic signed [7:0] quantize_value(input logic [31:0] v,
                                                         input logic [31:0] s);
        logic        nan_v;
        logic        nan_s;
        logic        inf_v;
        logic        inf_s;
        logic        zero_v;
        logic        zero_s;
        real         prod;
        real         mag;
        real         frac;
        logic [63:0] dbits;
        logic [63:0] mant;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          unb_exp;
        int          shift;
        int          t;
        nan_v  = (v[30:23] == EXP_MAX) && (v[22:0] != 23'd0);
        nan_s  = (s[30:23] == EXP_MAX) && (s[22:0] != 23'd0);
        inf_v  = (v[30:23] == EXP_MAX) && (v[22:0] == 23'd0);
        inf_s  = (s[30:23] == EXP_MAX) && (s[22:0] == 23'd0);
        zero_v = (v[30:0] == 31'd0);
        zero_s = (s[30:0] == 31'd0);
        // NaN, infinity and zero times infinity all land on integer-indefinite.
        if (nan_v || nan_s || inf_v || inf_s)
            return Q_NEG_SAT;
        if (zero_v || zero_s)
            return 8'sd0;
        // The double product of two singles is exact.
        prod = fp32_value(v) * fp32_value(s);
        dbits = $realtobits(prod);
        unb_exp = int'(dbits[62:52]) - 1023;
        mant = {11'd0, 1'b1, dbits[51:0]};
        shift = (unb_exp >= -126) ? 29 : 29 + (-126 - unb_exp);
        if (shift >= 60)
        begin
            kept = 64'd0;
        end
        else
        begin
            kept = mant >> shift;
            rem  = mant & ((64'd1 << shift) - 64'd1);
            half = 64'd1 << (shift - 1);
            if (rem > half || (rem == half && kept[0]))
                kept = kept + 64'd1;
        end
        mag = real'(kept) * (2.0 ** (unb_exp - 52 + shift));
        if (mag >= 2147483648.0)
            return Q_NEG_SAT;
        if (mag >= 128.0)
        begin
            t = 127;
        end
        else
        begin
            t = $rtoi(mag);
            frac = mag - real'(t);
            if (frac > 0.5 || (frac == 0.5 && (t % 2) == 1))
                t = t + 1;
            if (t > 127)
                t = 127;
        end
        return dbits[63] ? 8'(-t) : 8'(t);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Driver: hold the current item until transferred, then advance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.value_bits   <= 32'd0;
            in_ch.last_element <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid && in_ch.ready)
                expected_quants.push_back('{quantize_value(in_ch.value_bits, scale_now),
                                            in_ch.last_element});
            if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                elem_t nxt;
                nxt = pending_elems.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.value_bits   <= nxt.value_bits;
                in_ch.last_element <= nxt.last_element;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random and check every transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_quants.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result q=%0d last=%0b",
                                              out_ch.quantized, out_ch.last_out));
                end
                else
                begin
                    quant_t exp_q;
                    exp_q = expected_quants.pop_front();
                    if (out_ch.quantized !== exp_q.quantized)
                        report_mismatch($sformatf("quantized %0d, expected %0d",
                                                  out_ch.quantized, exp_q.quantized));
                    if (out_ch.last_out !== exp_q.last_out)
                        report_mismatch($sformatf("last_out %0b, expected %0b",
                                                  out_ch.last_out, exp_q.last_out));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** float_to_int8_quantizer_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] random_value();
        // Most values sit near the int8 range so rounding and clamping get exercised.
        if ($urandom_range(99) < 60)
            return {1'($urandom), 8'($urandom_range(134, 116)), 23'($urandom)};
        return $urandom;
    endfunction

    task automatic wait_idle();
        while (pending_elems.size() > 0 || in_ch.valid || expected_quants.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [31:0] s);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        scale_now = s;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_elem(input logic [31:0] v);
        pending_elems.push_back('{v, 1'($urandom)});
    endtask

    initial
    begin
        logic [31:0] scales[8];
        logic [31:0] directed[$];
        scales = '{32'h3F80_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
                   32'h0000_0001, 32'hC2FE_0000, 32'h3C23_D70A, 32'h42C8_0000};
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3F00_0000, 32'hBF00_0000,
                     32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000, 32'h42FE_CCCD,
                     32'h42FF_0000, 32'h4300_0000, 32'hC300_0000, 32'hC2FF_0000,
                     32'h4F00_0000, 32'hCF00_0000, 32'h4EFF_FFFF, 32'h7F7F_FFFF,
                     32'h0000_0001, 32'h807F_FFFF, 32'h46EA_6000, 32'h3F7F_FFFF};
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        scale_now      = SCALE_RESET;
        cfg_we         = 1'b0;
        cfg_wdata      = 32'd0;
        rst_n          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset scale of 1.0 first, with directed corner values.
        foreach (directed[i])
            push_elem(directed[i]);
        wait_idle();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            write_scale(ph < 8 ? scales[ph] : {1'($urandom), 8'($urandom_range(133, 120)),
                                                23'($urandom)});
            for (int n = 0; n < 200; n++)
                push_elem(random_value());
            wait_idle();
        end

        if (error_count == 0)
        begin
            $display("** float_to_int8_quantizer_core: PASSED **");
        end
        else
        begin
            $display("** float_to_int8_quantizer_core: FAILED **");
        end
        $finish;
    end

endmodule
